>>> sv/fcgi_pkg.sv
// Shared constants and types for the FastCGI record deframer.
`timescale 1ns / 1ps

package fcgi_pkg;

  // Parser phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_STDOUT = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Event codes on the result channel
  localparam logic [1:0] EV_PAYLOAD       = 2'd0;
  localparam logic [1:0] EV_STDOUT_CLOSED = 2'd1;
  localparam logic [1:0] EV_FINISH_OK     = 2'd2;
  localparam logic [1:0] EV_FINISH_ERR    = 2'd3;

  // Record header values
  localparam logic [7:0] REC_VERSION     = 8'd1;
  localparam logic [7:0] REC_END_REQUEST = 8'd3;
  localparam logic [7:0] REC_STDOUT      = 8'd6;

  // Header byte positions
  localparam logic [2:0] HP_VERSION  = 3'd0;
  localparam logic [2:0] HP_TYPE     = 3'd1;
  localparam logic [2:0] HP_REQ_HI   = 3'd2;
  localparam logic [2:0] HP_REQ_LO   = 3'd3;
  localparam logic [2:0] HP_LEN_HI   = 3'd4;
  localparam logic [2:0] HP_LEN_LO   = 3'd5;
  localparam logic [2:0] HP_PADDING  = 3'd6;
  localparam logic [2:0] HP_RESERVED = 3'd7;

  localparam logic [15:0] SESSION_ID_RESET = 16'd1;

  // One result beat
  typedef struct packed {
    logic [1:0] event_code;
    logic [7:0] payload_byte;
  } evt_t;

endpackage

>>> sv/fcgi_if.sv
// Valid/ready channel interfaces for the input bytes and the result events.
`timescale 1ns / 1ps

interface fcgi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       source_closed;

  modport source (output valid, output stream_byte, output source_closed, input ready);
  modport sink   (input valid, input stream_byte, input source_closed, output ready);
endinterface

interface fcgi_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic [7:0] payload_byte;

  modport source (output valid, output event_code, output payload_byte, input ready);
  modport sink   (input valid, input event_code, input payload_byte, output ready);
endinterface

>>> sv/fcgi_core.sv
// Record parser: header capture, length counting and event generation.
`timescale 1ns / 1ps

module fcgi_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              beat_acc,
  input  logic [7:0]        beat_byte,
  input  logic              beat_closed,
  output logic              res_vld,
  output fcgi_pkg::evt_t    res
);

  // Control state
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        ended_r, ended_nxt;
  logic [15:0] sess_id_r;

  // Header fields and length counter
  logic [7:0]  ver_r, ver_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] req_r, req_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  pad_r, pad_nxt;
  logic [16:0] rem_r, rem_nxt;

  logic [16:0] rem_dec;
  logic [16:0] body_len;
  logic        hdr_ok;
  logic        end_rec;

  assign rem_dec  = rem_r - 17'd1;
  assign body_len = {1'b0, len_r} + {9'd0, pad_r};
  assign hdr_ok   = (ver_r == fcgi_pkg::REC_VERSION) && (req_r == sess_id_r);
  assign end_rec  = (type_r == fcgi_pkg::REC_END_REQUEST);

  // Next-state and result logic for one accepted beat
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    ended_nxt = ended_r;
    ver_nxt   = ver_r;
    type_nxt  = type_r;
    req_nxt   = req_r;
    len_nxt   = len_r;
    pad_nxt   = pad_r;
    rem_nxt   = rem_r;
    res_vld   = 1'b0;
    res       = '0;

    if (beat_acc && (phase_r != fcgi_pkg::PH_DONE)) begin
      if (beat_closed) begin
        phase_nxt      = fcgi_pkg::PH_DONE;
        res_vld        = 1'b1;
        res.event_code = ended_r ? fcgi_pkg::EV_FINISH_OK : fcgi_pkg::EV_FINISH_ERR;
      end else begin
        unique case (phase_r)
          fcgi_pkg::PH_HEADER: begin
            pos_nxt = pos_r + 3'd1;
            case (pos_r)
              fcgi_pkg::HP_VERSION: ver_nxt = beat_byte;
              fcgi_pkg::HP_TYPE:    type_nxt = beat_byte;
              fcgi_pkg::HP_REQ_HI:  req_nxt = {beat_byte, req_r[7:0]};
              fcgi_pkg::HP_REQ_LO:  req_nxt = {req_r[15:8], beat_byte};
              fcgi_pkg::HP_LEN_HI:  len_nxt = {beat_byte, len_r[7:0]};
              fcgi_pkg::HP_LEN_LO:  len_nxt = {len_r[15:8], beat_byte};
              fcgi_pkg::HP_PADDING: pad_nxt = beat_byte;
              default: begin
                // reserved byte: header complete
                if (!hdr_ok) begin
                  phase_nxt      = fcgi_pkg::PH_DONE;
                  res_vld        = 1'b1;
                  res.event_code = fcgi_pkg::EV_FINISH_ERR;
                end else if (type_r == fcgi_pkg::REC_STDOUT) begin
                  if (len_r == 16'd0) begin
                    // empty stdout record closes the stream, then skip padding
                    res_vld        = 1'b1;
                    res.event_code = fcgi_pkg::EV_STDOUT_CLOSED;
                    rem_nxt        = {9'd0, pad_r};
                    if (pad_r != 8'd0) phase_nxt = fcgi_pkg::PH_SKIP;
                    else if (ended_r)  phase_nxt = fcgi_pkg::PH_DONE;
                    else               phase_nxt = fcgi_pkg::PH_HEADER;
                  end else begin
                    rem_nxt   = {1'b0, len_r};
                    phase_nxt = fcgi_pkg::PH_STDOUT;
                  end
                end else begin
                  // any other record: skip content and padding
                  ended_nxt = ended_r | end_rec;
                  rem_nxt   = body_len;
                  if (body_len != 17'd0) begin
                    phase_nxt = fcgi_pkg::PH_SKIP;
                  end else if (ended_r || end_rec) begin
                    phase_nxt      = fcgi_pkg::PH_DONE;
                    res_vld        = 1'b1;
                    res.event_code = fcgi_pkg::EV_FINISH_OK;
                  end else begin
                    phase_nxt = fcgi_pkg::PH_HEADER;
                  end
                end
              end
            endcase
          end
          fcgi_pkg::PH_STDOUT: begin
            res_vld          = 1'b1;
            res.event_code   = fcgi_pkg::EV_PAYLOAD;
            res.payload_byte = beat_byte;
            rem_nxt          = rem_dec;
            if (rem_dec == 17'd0) begin
              // content done: move on to padding
              rem_nxt = {9'd0, pad_r};
              if (pad_r != 8'd0) phase_nxt = fcgi_pkg::PH_SKIP;
              else if (ended_r)  phase_nxt = fcgi_pkg::PH_DONE;
              else               phase_nxt = fcgi_pkg::PH_HEADER;
            end
          end
          fcgi_pkg::PH_SKIP: begin
            rem_nxt = rem_dec;
            if (rem_dec == 17'd0) begin
              if (ended_r) begin
                phase_nxt      = fcgi_pkg::PH_DONE;
                res_vld        = 1'b1;
                res.event_code = fcgi_pkg::EV_FINISH_OK;
              end else begin
                phase_nxt = fcgi_pkg::PH_HEADER;
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= fcgi_pkg::PH_HEADER;
      pos_r     <= fcgi_pkg::HP_VERSION;
      ended_r   <= 1'b0;
      sess_id_r <= fcgi_pkg::SESSION_ID_RESET;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      ended_r <= ended_nxt;
      if (cfg_we) sess_id_r <= cfg_wdata;
    end
  end

  // Header fields and counter, written before they are read
  always_ff @(posedge clk) begin
    ver_r  <= ver_nxt;
    type_r <= type_nxt;
    req_r  <= req_nxt;
    len_r  <= len_nxt;
    pad_r  <= pad_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

>>> sv/fcgi_out_reg.sv
// Output register stage for result beats.
`timescale 1ns / 1ps

module fcgi_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  fcgi_pkg::evt_t load_data,
  output logic           take_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output fcgi_pkg::evt_t out_data
);

  logic           valid_r, valid_nxt;
  fcgi_pkg::evt_t data_r;

  // Stage can take a new beat when empty or being drained this cycle
  assign take_ok   = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= load_data;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> sv/fastcgi_record_deframer.sv
// Top level of the FastCGI record deframer.
//
// in_chan carries one byte of the application stream per beat, or a close
// marker (source_closed high, byte ignored). out_chan carries at most one
// event per input beat: a stdout content byte, stdout closed, finished ok or
// finished error. cfg_wr_en/cfg_wr_data set the expected request id
// (reset value 1); write it only while no beat is in flight.
// Throughput: one input beat per cycle while out_chan takes its events. Each
// beat is parsed by one level of header/counter logic and its event lands in
// the output register, so an event appears on out_chan in the cycle after its
// beat is accepted.
// Reset (rst_n low, synchronous) returns the parser to the start of a
// header with no end mark and drops any pending event. When out_chan stalls,
// in_chan.ready drops only while the output register holds an event that
// has not been taken; it returns in the cycle the receiver takes it.
// After a finish event every further beat is accepted and dropped until
// the next reset.
`timescale 1ns / 1ps

module fastcgi_record_deframer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  fcgi_in_if.sink       in_chan,
  fcgi_out_if.source    out_chan
);

  logic           beat_acc;
  logic           take_ok;
  logic           res_vld;
  fcgi_pkg::evt_t res;
  fcgi_pkg::evt_t out_data;

  // Accept a beat whenever the output stage has room
  assign in_chan.ready = take_ok;
  assign beat_acc      = in_chan.valid && take_ok;

  fcgi_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_wr_en),
    .cfg_wdata   (cfg_wr_data),
    .beat_acc    (beat_acc),
    .beat_byte   (in_chan.stream_byte),
    .beat_closed (in_chan.source_closed),
    .res_vld     (res_vld),
    .res         (res)
  );

  fcgi_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_vld),
    .load_data (res),
    .take_ok   (take_ok),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign out_chan.event_code   = out_data.event_code;
  assign out_chan.payload_byte = out_data.payload_byte;

endmodule
